>>> rtl/btl_pkg.sv
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types, constants and helpers for the bitmap text layout block.
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int GLYPHS      = 128;
  localparam int GLYPH_AW    = $clog2(GLYPHS);
  localparam int ENTRY_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;

  localparam logic [7:0]  CODE_END     = 8'd0;
  localparam logic [7:0]  CODE_NEWLINE = 8'd10;
  localparam logic [7:0]  CODE_SPACE   = 8'd32;
  localparam logic [7:0]  CODE_FIRST   = 8'd33;
  localparam logic [10:0] SAT_MAX      = 11'd2047;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_CHAR = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_FONT_HEIGHT = 3'd4,
    REG_SPACE_WIDTH = 3'd5
  } reg_index_t;

  // Clamp a 12-bit sum to the 11-bit pen range.
  function automatic logic [10:0] sat11(input logic [11:0] s);
    sat11 = s[11] ? SAT_MAX : s[10:0];
  endfunction

endpackage

>>> rtl/btl_ram.sv
// ----------------------------------------------------------------------------
// btl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module btl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bitmap_text_layout_clip.sv
// ----------------------------------------------------------------------------
// bitmap_text_layout_clip
// Lays out text from a loaded glyph table and issues clipped blit commands.
// m_tvalid for a character is set from the output register after its glyph RAM
// read and second stage. Throughput: one beat per cycle unless the output stalls;
// the glyph RAM read feeds the pen update, and the pen register closes that loop.
// Reset: pen, stop flag, pipeline valids and configuration registers return to
// defaults; the glyph table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
module bitmap_text_layout_clip (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // char_code[7:0], glyph_index[14:8], glyph_row[30:15], glyph_width[38:31]
  input  logic [btl_pkg::IN_DATA_W-1:0]    s_tdata,
  // opcode
  input  logic                             s_tuser,
  // string_end
  input  logic                             s_tlast,
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // dest_x[10:0], dest_y[21:11], source_row[37:22], blit_width[45:38],
  // blit_height[53:46]
  output logic [btl_pkg::OUT_DATA_W-1:0]   m_tdata,
  // configuration
  input  logic                             cfg_wen,
  input  logic [btl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [9:0]  origin_x;
  logic [9:0]  origin_y;
  logic [10:0] clip_width;
  logic [10:0] clip_height;
  logic [7:0]  font_height;
  logic [7:0]  space_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= 10'd0;
      origin_y    <= 10'd0;
      clip_width  <= 11'd320;
      clip_height <= 11'd256;
      font_height <= 8'd8;
      space_width <= 8'd4;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        btl_pkg::REG_ORIGIN_X:    origin_x    <= cfg_data[9:0];
        btl_pkg::REG_ORIGIN_Y:    origin_y    <= cfg_data[9:0];
        btl_pkg::REG_CLIP_WIDTH:  clip_width  <= cfg_data;
        btl_pkg::REG_CLIP_HEIGHT: clip_height <= cfg_data;
        btl_pkg::REG_FONT_HEIGHT: font_height <= cfg_data[7:0];
        btl_pkg::REG_SPACE_WIDTH: space_width <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [7:0]  in_code;
  logic [6:0]  in_gidx;
  logic [15:0] in_grow;
  logic [7:0]  in_gwid;
  assign in_code = s_tdata[7:0];
  assign in_gidx = s_tdata[14:8];
  assign in_grow = s_tdata[30:15];
  assign in_gwid = s_tdata[38:31];

  logic accept;
  logic accept_char;
  logic accept_load;
  assign accept      = s_tvalid && s_tready;
  assign accept_char = accept && (s_tuser == btl_pkg::OP_CHAR);
  assign accept_load = accept && (s_tuser == btl_pkg::OP_LOAD);

  logic                         ram_we;
  logic [btl_pkg::GLYPH_AW-1:0] ram_waddr;
  logic [btl_pkg::GLYPH_AW-1:0] ram_raddr;
  logic [7:0]                   code_off;
  logic [btl_pkg::ENTRY_W-1:0]  entry;

  assign ram_we    = accept_load && ({1'b0, in_gidx} < 8'(btl_pkg::GLYPHS));
  assign ram_waddr = btl_pkg::GLYPH_AW'(in_gidx);
  assign code_off  = in_code - btl_pkg::CODE_FIRST;
  assign ram_raddr = code_off[btl_pkg::GLYPH_AW-1:0];

  btl_ram #(
    .WIDTH (btl_pkg::ENTRY_W),
    .DEPTH (btl_pkg::GLYPHS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_gwid, in_grow}),
    .re    (accept_char),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  // second stage: character waiting on its table entry
  logic       s1_valid;
  logic [7:0] s1_code;
  logic       s1_last;
  logic       s1_go;

  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept_char;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_char) begin
      s1_code <= in_code;
      s1_last <= s_tlast;
    end
  end

  // pen state
  logic [10:0] pen_column;
  logic [10:0] pen_row;
  logic        stopped;
  logic [10:0] pen_column_next;
  logic [10:0] pen_row_next;
  logic        stopped_next;

  logic [10:0] row_nl;
  logic [10:0] col_sp;
  logic [10:0] col_rem;
  logic [10:0] row_rem;
  logic [7:0]  blit_w;
  logic [7:0]  blit_h;
  logic        printable;
  logic [8:0]  s1_off;
  logic        emit;

  assign row_nl  = btl_pkg::sat11({1'b0, pen_row} + {4'd0, font_height});
  assign col_sp  = btl_pkg::sat11({1'b0, pen_column} + {4'd0, space_width});
  assign col_rem = clip_width - pen_column;
  assign row_rem = clip_height - pen_row;
  assign s1_off  = {1'b0, s1_code} - {1'b0, btl_pkg::CODE_FIRST};
  assign printable = (s1_code >= btl_pkg::CODE_FIRST) && (pen_column < clip_width)
                     && (s1_off < 9'(btl_pkg::GLYPHS));

  always_comb begin
    if ({3'd0, entry[23:16]} < col_rem) begin
      blit_w = entry[23:16];
    end else begin
      blit_w = col_rem[7:0];
    end
    if (pen_row >= clip_height) begin
      blit_h = 8'd0;
    end else if ({3'd0, font_height} < row_rem) begin
      blit_h = font_height;
    end else begin
      blit_h = row_rem[7:0];
    end
  end

  always_comb begin
    pen_column_next = pen_column;
    pen_row_next    = pen_row;
    stopped_next    = stopped;
    emit            = 1'b0;
    if (!stopped) begin
      if (s1_code == btl_pkg::CODE_END) begin
        stopped_next = 1'b1;
      end else if (s1_code == btl_pkg::CODE_NEWLINE) begin
        pen_column_next = 11'd0;
        pen_row_next    = row_nl;
        stopped_next    = (row_nl >= clip_height);
      end else if (s1_code == btl_pkg::CODE_SPACE) begin
        pen_column_next = col_sp;
      end else if (printable && (blit_w != 8'd0)) begin
        emit            = (blit_h != 8'd0);
        pen_column_next = btl_pkg::sat11({1'b0, pen_column} + {4'd0, blit_w});
      end
    end
    // end of string: restart the pen for the next string
    if (s1_last) begin
      pen_column_next = 11'd0;
      pen_row_next    = 11'd0;
      stopped_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_column <= 11'd0;
      pen_row    <= 11'd0;
      stopped    <= 1'b0;
    end else if (s1_go) begin
      pen_column <= pen_column_next;
      pen_row    <= pen_row_next;
      stopped    <= stopped_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      m_tdata <= {2'b00, blit_h, blit_w, entry[15:0],
                  btl_pkg::sat11({2'b00, origin_y} + {1'b0, pen_row}),
                  btl_pkg::sat11({2'b00, origin_x} + {1'b0, pen_column})};
    end
  end

  // checks
  a_blit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[45:38] != 8'd0) && (m_tdata[53:46] != 8'd0))
    else $error("blit with zero width or height");

  a_char_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> s1_valid)
    else $error("accepted character lost before table lookup");

  a_string_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (pen_column == 11'd0) && (pen_row == 11'd0) && !stopped)
    else $error("pen not restarted after end of string");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks bitmap_text_layout_clip: loads glyph entries, streams strings under
// several area settings and compares every blit beat against a layout
// predictor, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 30;

  localparam logic [7:0] CODE_BELL   = 8'd7;
  localparam logic [7:0] CODE_TOP    = 8'hFF;
  localparam logic [7:0] LAST_GLYPH  =
    8'(int'(btl_pkg::CODE_FIRST) + btl_pkg::GLYPHS - 1);
  localparam logic [7:0] PAST_GLYPHS =
    8'(int'(btl_pkg::CODE_FIRST) + btl_pkg::GLYPHS);

  typedef struct {
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [15:0] source_row;
    logic [7:0]  blit_width;
    logic [7:0]  blit_height;
  } blit_t;

  class layout_board;
    logic [btl_pkg::ENTRY_W-1:0] glyph_rom [btl_pkg::GLYPHS];
    logic [10:0] pen_x;
    logic [10:0] pen_y;
    bit          halted;
    logic [9:0]  org_x;
    logic [9:0]  org_y;
    logic [10:0] clip_w;
    logic [10:0] clip_h;
    logic [7:0]  font_h;
    logic [7:0]  space_w;
    blit_t       pending [$];
    int          fails;

    function new();
      pen_x   = '0;
      pen_y   = '0;
      halted  = 1'b0;
      org_x   = '0;
      org_y   = '0;
      clip_w  = 11'd320;
      clip_h  = 11'd256;
      font_h  = 8'd8;
      space_w = 8'd4;
      fails   = 0;
    endfunction

    function logic [10:0] clamp_sum(int a, int b);
      return (a + b > int'(btl_pkg::SAT_MAX)) ? btl_pkg::SAT_MAX : 11'(a + b);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fails++;
    endtask

    function void set_reg(btl_pkg::reg_index_t idx, logic [10:0] v);
      case (idx)
        btl_pkg::REG_ORIGIN_X:    org_x   = v[9:0];
        btl_pkg::REG_ORIGIN_Y:    org_y   = v[9:0];
        btl_pkg::REG_CLIP_WIDTH:  clip_w  = v;
        btl_pkg::REG_CLIP_HEIGHT: clip_h  = v;
        btl_pkg::REG_FONT_HEIGHT: font_h  = v[7:0];
        btl_pkg::REG_SPACE_WIDTH: space_w = v[7:0];
        default: ;
      endcase
    endfunction

    // Store a load beat in the glyph table, or advance the pen for one accepted character and queue the blit it causes.
    function void note_beat(btl_pkg::opcode_t op, logic [7:0] code, logic [6:0] gidx,
                            logic [15:0] grow, logic [7:0] gwid, bit last);
      int    slot;
      int    w;
      int    h;
      blit_t b;
      if (op == btl_pkg::OP_LOAD) begin
        glyph_rom[gidx] = {gwid, grow};
        return;
      end
      if (!halted) begin
        slot = int'(code) - int'(btl_pkg::CODE_FIRST);
        if (code == btl_pkg::CODE_END) begin
          halted = 1'b1;
        end else if (code == btl_pkg::CODE_NEWLINE) begin
          pen_x = '0;
          pen_y = clamp_sum(int'(pen_y), int'(font_h));
          if (pen_y >= clip_h) halted = 1'b1;
        end else if (code == btl_pkg::CODE_SPACE) begin
          pen_x = clamp_sum(int'(pen_x), int'(space_w));
        end else if (slot >= 0 && slot < btl_pkg::GLYPHS && pen_x < clip_w) begin
          w = int'(glyph_rom[slot][23:16]);
          if (int'(clip_w) - int'(pen_x) < w) w = int'(clip_w) - int'(pen_x);
          h = 0;
          if (pen_y < clip_h) begin
            h = int'(font_h);
            if (int'(clip_h) - int'(pen_y) < h) h = int'(clip_h) - int'(pen_y);
          end
          if (w != 0) begin
            if (h != 0) begin
              b.dest_x      = clamp_sum(int'(org_x), int'(pen_x));
              b.dest_y      = clamp_sum(int'(org_y), int'(pen_y));
              b.source_row  = glyph_rom[slot][15:0];
              b.blit_width  = 8'(w);
              b.blit_height = 8'(h);
              pending.push_back(b);
            end
            pen_x = clamp_sum(int'(pen_x), w);
          end
        end
      end
      if (last) begin
        pen_x  = '0;
        pen_y  = '0;
        halted = 1'b0;
      end
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_blit(logic [btl_pkg::OUT_DATA_W-1:0] d);
      blit_t want;
      if (pending.size() == 0) begin
        report($sformatf("blit beat %h with nothing pending", d));
        return;
      end
      want = pending.pop_front();
      compare_field("dest_x", 16'(d[10:0]), 16'(want.dest_x));
      compare_field("dest_y", 16'(d[21:11]), 16'(want.dest_y));
      compare_field("source_row", d[37:22], want.source_row);
      compare_field("blit_width", 16'(d[45:38]), 16'(want.blit_width));
      compare_field("blit_height", 16'(d[53:46]), 16'(want.blit_height));
    endtask
  endclass

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [btl_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic                           s_tuser   = 1'b0;
  logic                           s_tlast   = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [btl_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_wen   = 1'b0;
  logic [btl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [btl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  bit          calm = 1'b0;
  bit          loaded [btl_pkg::GLYPHS];
  int          idle_cycles = 0;
  layout_board board = new();

  bitmap_text_layout_clip dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_blit(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: ready stretches mixed with stall bursts, always ready when calm.
  initial begin
    int span;
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        span = $urandom_range(1, 40);
        @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        span = $urandom_range(1, 18);
        @(negedge clk);
        m_tready <= 1'b0;
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  task automatic send_beat(btl_pkg::opcode_t op, logic [7:0] code, logic [6:0] gidx,
                           logic [15:0] grow, logic [7:0] gwid, bit last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {1'b0, gwid, grow, gidx, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_beat(op, code, gidx, grow, gwid, last);
    if (op == btl_pkg::OP_LOAD) loaded[gidx] = 1'b1;
  endtask

  task automatic send_load(logic [6:0] gidx);
    logic [7:0] gwid;
    case ($urandom_range(0, 7))
      0:       gwid = 8'd0;
      6, 7:    gwid = 8'($urandom_range(0, 255));
      default: gwid = 8'($urandom_range(1, 24));
    endcase
    send_beat(btl_pkg::OP_LOAD, 8'($urandom), gidx, 16'($urandom), gwid, 1'($urandom));
  endtask

  // Load the entry first if the character would read one never written.
  task automatic send_char(logic [7:0] code, bit last);
    int slot;
    slot = int'(code) - int'(btl_pkg::CODE_FIRST);
    if (slot >= 0 && slot < btl_pkg::GLYPHS && !loaded[slot]) send_load(7'(slot));
    send_beat(btl_pkg::OP_CHAR, code, 7'($urandom), 16'($urandom), 8'($urandom), last);
  endtask

  function automatic logic [7:0] pick_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) return 8'($urandom_range(int'(btl_pkg::CODE_FIRST), int'(LAST_GLYPH)));
    else if (roll < 75) return btl_pkg::CODE_SPACE;
    else if (roll < 85) return btl_pkg::CODE_NEWLINE;
    else if (roll < 88) return btl_pkg::CODE_END;
    else return 8'($urandom);
  endfunction

  function automatic int pick_clip();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 48);
      1:       return $urandom_range(0, 1024);
      2:       return 1024;
      default: return $urandom_range(256, 1024);
    endcase
  endfunction

  task automatic run_directed();
    send_beat(btl_pkg::OP_LOAD, btl_pkg::CODE_END, 7'd0, 16'h0000, 8'd5, 1'b0);
    // an end mark on a load must leave the pen alone
    send_beat(btl_pkg::OP_LOAD, CODE_TOP, 7'h7F, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(btl_pkg::OP_LOAD, btl_pkg::CODE_SPACE, 7'd1, 16'h1234, 8'd0, 1'b0);
    send_beat(btl_pkg::OP_LOAD, btl_pkg::CODE_NEWLINE, 7'd2, 16'h5A5A, 8'd1, 1'b0);
    send_char(btl_pkg::CODE_FIRST, 1'b0);
    send_char(btl_pkg::CODE_FIRST + 8'd1, 1'b0);   // zero width glyph
    send_char(btl_pkg::CODE_SPACE, 1'b0);
    send_char(LAST_GLYPH, 1'b0);
    send_char(LAST_GLYPH, 1'b0);                   // clipped at the right edge
    send_char(btl_pkg::CODE_FIRST, 1'b0);          // starts at the right edge
    send_char(CODE_BELL, 1'b0);
    send_char(PAST_GLYPHS, 1'b0);
    send_char(CODE_TOP, 1'b0);
    send_char(btl_pkg::CODE_NEWLINE, 1'b0);
    send_char(btl_pkg::CODE_FIRST + 8'd2, 1'b0);
    send_char(btl_pkg::CODE_END, 1'b0);
    send_char(btl_pkg::CODE_FIRST, 1'b1);          // ignored, closes the string
    send_char(btl_pkg::CODE_FIRST, 1'b1);
  endtask

  task automatic run_strings(int n);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray beat outside any well-formed string
        if ($urandom_range(0, 1) != 0) send_load(7'($urandom));
        else send_char(8'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, 24);
        if (len > n - sent) len = n - sent;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) send_load(7'($urandom));
          send_char(pick_code(), k == len - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic write_reg(btl_pkg::reg_index_t idx, int v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(v);
    @(posedge clk);
    board.set_reg(idx, 11'(v));
  endtask

  task automatic set_area(int ox, int oy, int cw, int ch, int fh, int sw);
    write_reg(btl_pkg::REG_ORIGIN_X, ox);
    write_reg(btl_pkg::REG_ORIGIN_Y, oy);
    write_reg(btl_pkg::REG_CLIP_WIDTH, cw);
    write_reg(btl_pkg::REG_CLIP_HEIGHT, ch);
    write_reg(btl_pkg::REG_FONT_HEIGHT, fh);
    write_reg(btl_pkg::REG_SPACE_WIDTH, sw);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Drop valid, drain pending blits, then allow for beats still in flight.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int p;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: set_area(1023, 1023, 1024, 1024, 255, 255);
        1: set_area(0, 0, 0, 0, 1, 0);
        // over range: origins keep their low ten bits, pens saturate
        2: set_area(2047, 2047, 2047, 2047, 255, 255);
        3: set_area($urandom_range(0, 1023), $urandom_range(0, 1023), pick_clip(),
                    pick_clip(), 0, $urandom_range(0, 40));
        default: set_area($urandom_range(0, 1023), $urandom_range(0, 1023), pick_clip(),
                          pick_clip(),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                                      : $urandom_range(1, 255),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16)
                                                      : $urandom_range(0, 255));
      endcase
      calm = (p == PHASES - 1);
      run_strings(PHASE_ITEMS);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
